// ===== hw/rtl/ksel_pkg.sv =====
package ksel_pkg;

   // Store geometry.
   localparam int CAPACITY  = 16;
   localparam int TAG_BITS  = 32;
   localparam int DIST_BITS = 32;
   localparam int KEEP_BITS = 5;
   localparam int KIND_BITS = 2;
   localparam int OCC_BITS  = $clog2(CAPACITY + 1);
   localparam int IDX_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CMP_BITS  = (OCC_BITS > KEEP_BITS) ? OCC_BITS : KEEP_BITS;

   localparam logic [KEEP_BITS-1:0] KEEP_RESET = KEEP_BITS'(16);

   // Request opcodes.
   localparam logic OP_OFFER = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // Result kinds.
   localparam logic [KIND_BITS-1:0] KIND_REJECT = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_KEPT   = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_EMPTY  = 2'd2;

   typedef struct packed {
      logic [TAG_BITS-1:0]  tag;
      logic [DIST_BITS-1:0] distance;
   } entry_type;

   // Per-cycle command broadcast to every cell of the chain.
   typedef struct packed {
      logic insert;
      logic shift_out;
   } cell_ctl_type;

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

endpackage

// ===== hw/rtl/ksel_cell.sv =====
module ksel_cell
   import ksel_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic         active,
   input  entry_type    offer,
   input  logic         prev_shift_up,
   input  entry_type    prev_entry,
   input  entry_type    next_entry,
   output logic         shift_up,
   output entry_type    entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // An empty cell counts as holding an infinite distance.
   assign shift_up = !active || (entry_ff.distance > offer.distance);
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert && shift_up) begin
         entry_in = prev_shift_up ? prev_entry : offer;
      end else if (ctl.shift_out) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== hw/rtl/k_smallest_selector_with_eviction.sv =====
// A stored offer produces no result; a rejected or evicting offer has its result
// registered on acceptance. A drain of N entries first moves the state to drain, then
// emits one item per cycle as the chain shifts it out, unless the output stalls; an
// empty drain gets a registered result. One offer per cycle while the output is not
// stalled; a drain blocks the input until all N entries are out. Reset (synchronous,
// active high) empties the store, sets keep_count to 16; entry data is not cleared.
module k_smallest_selector_with_eviction
   import ksel_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_opcode,
   input  logic [TAG_BITS-1:0]   req_item_tag,
   input  logic [DIST_BITS-1:0]  req_distance,
   // Response channel.
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [KIND_BITS-1:0]  rsp_kind,
   output logic [TAG_BITS-1:0]   rsp_out_tag,
   output logic [DIST_BITS-1:0]  rsp_out_distance,
   output logic                  rsp_last,
   // Configuration.
   input  logic                  csr_wr_en,
   input  logic [KEEP_BITS-1:0]  csr_wr_data
);

   // The store is a chain of cells kept sorted by ascending distance, with equal
   // distances in order of arrival. Cells below the occupancy count hold entries.
   // An offer is broadcast to all cells; every cell whose entry is larger moves one
   // place up, and the cell just above the last smaller-or-equal entry takes the offer.
   // On eviction the largest entry sits at the top of the occupied range, so the shift
   // pushes it past the count (off the chain when full), where it is no longer seen.

   state_type state_ff;
   state_type state_in;

   logic [KEEP_BITS-1:0] keep_count_ff;
   logic [OCC_BITS-1:0]  occ_ff;
   logic [OCC_BITS-1:0]  occ_in;

   logic                 rsp_valid_ff;
   logic [KIND_BITS-1:0] rsp_kind_ff;
   logic [KIND_BITS-1:0] rsp_kind_in;
   logic [TAG_BITS-1:0]  rsp_tag_ff;
   logic [TAG_BITS-1:0]  rsp_tag_in;
   logic [DIST_BITS-1:0] rsp_dist_ff;
   logic [DIST_BITS-1:0] rsp_dist_in;
   logic                 rsp_last_ff;
   logic                 rsp_last_in;
   logic                 emit;

   logic                 out_free;
   logic                 req_take;
   cell_ctl_type         ctl;
   entry_type            offer;
   entry_type            entry_q [CAPACITY];
   logic                 shift_up_q [CAPACITY];
   logic                 active_q [CAPACITY];
   entry_type            top_entry;
   logic [IDX_BITS-1:0]  top_idx;
   logic [CMP_BITS-1:0]  limit;
   logic [CMP_BITS-1:0]  occ_cmp;

   // The output register can take a new item when it is empty or being emptied.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_take  = req_valid && !req_stall;

   assign offer.tag      = req_item_tag;
   assign offer.distance = req_distance;

   // Effective limit: keep_count clamped to the chain length.
   assign limit   = (CMP_BITS'(keep_count_ff) > CMP_BITS'(CAPACITY)) ?
                    CMP_BITS'(CAPACITY) : CMP_BITS'(keep_count_ff);
   assign occ_cmp = CMP_BITS'(occ_ff);

   // The largest kept entry is the topmost occupied cell.
   assign top_idx   = IDX_BITS'(occ_ff - OCC_BITS'(1));
   assign top_entry = entry_q[top_idx];

   // Chain of cells. The bottom cell sees the offer as its lower neighbor and the
   // top cell feeds itself on a drain shift.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic      prev_shift_up;
      entry_type prev_entry;
      entry_type next_entry;

      assign active_q[i] = OCC_BITS'(i) < occ_ff;

      if (i == 0) begin : g_bottom
         assign prev_shift_up = 1'b0;
         assign prev_entry    = offer;
      end else begin : g_inner
         assign prev_shift_up = shift_up_q[i-1];
         assign prev_entry    = entry_q[i-1];
      end

      if (i == CAPACITY - 1) begin : g_top
         assign next_entry = entry_q[i];
      end else begin : g_below
         assign next_entry = entry_q[i+1];
      end

      ksel_cell u_cell (
         .clock         (clock),
         .ctl           (ctl),
         .active        (active_q[i]),
         .offer         (offer),
         .prev_shift_up (prev_shift_up),
         .prev_entry    (prev_entry),
         .next_entry    (next_entry),
         .shift_up      (shift_up_q[i]),
         .entry         (entry_q[i])
      );
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && req_opcode == OP_DRAIN && occ_ff != '0) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (out_free && occ_ff == OCC_BITS'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Chain commands, occupancy update and the result to load.
   always_comb begin
      ctl          = '0;
      occ_in       = occ_ff;
      emit         = 1'b0;
      rsp_kind_in  = KIND_REJECT;
      rsp_tag_in   = req_item_tag;
      rsp_dist_in  = req_distance;
      rsp_last_in  = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_opcode == OP_DRAIN) begin
                  // A non-empty store is drained in the following cycles.
                  if (occ_ff == '0) begin
                     emit        = 1'b1;
                     rsp_kind_in = KIND_EMPTY;
                     rsp_tag_in  = '0;
                     rsp_dist_in = '0;
                  end
               end else if (limit == '0) begin
                  emit = 1'b1;
               end else if (occ_cmp < limit) begin
                  ctl.insert = 1'b1;
                  occ_in     = occ_ff + OCC_BITS'(1);
               end else if (req_distance >= top_entry.distance) begin
                  // Not better than the worst kept entry: the offer goes back.
                  emit = 1'b1;
               end else begin
                  // Evict the worst entry, latest arrival among equals.
                  emit        = 1'b1;
                  rsp_tag_in  = top_entry.tag;
                  rsp_dist_in = top_entry.distance;
                  ctl.insert  = 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               emit          = 1'b1;
               rsp_kind_in   = KIND_KEPT;
               rsp_tag_in    = entry_q[0].tag;
               rsp_dist_in   = entry_q[0].distance;
               rsp_last_in   = occ_ff == OCC_BITS'(1);
               ctl.shift_out = 1'b1;
               occ_in        = occ_ff - OCC_BITS'(1);
            end
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         occ_ff        <= '0;
         keep_count_ff <= KEEP_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         if (csr_wr_en) begin
            keep_count_ff <= csr_wr_data;
         end
         if (out_free) begin
            rsp_valid_ff <= emit;
         end
      end
   end

   // Result payload; loaded only together with a new valid item.
   always_ff @(posedge clock) begin
      if (emit && out_free) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_tag_ff  <= rsp_tag_in;
         rsp_dist_ff <= rsp_dist_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_out_tag      = rsp_tag_ff;
   assign rsp_out_distance = rsp_dist_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef SYNTHESIS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_BITS'(CAPACITY))
      else $error("occupancy beyond chain length");

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> occ_ff != '0)
      else $error("drain running on an empty store");

   a_drain_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && out_free && occ_ff == OCC_BITS'(1))
      |=> (state_ff == ST_IDLE && occ_ff == '0 && rsp_last_ff))
      else $error("drain did not finish with a last item");

   a_sorted: assert property (@(posedge clock) disable iff (reset)
      (active_q[1] && state_ff == ST_IDLE) |->
      entry_q[0].distance <= entry_q[1].distance)
      else $error("chain bottom out of order");
`endif

endmodule
